[rtl/core/bqss_pkg.sv]
`timescale 1ns / 1ps
package bqss_pkg;

    localparam int MaxStates = 8;
    localparam int FracBits  = 16;

    typedef enum logic [2:0] {
        REG_STATE_COUNT   = 3'd0,
        REG_ADVANCE_MODE  = 3'd1,
        REG_OPTION_FLAGS  = 3'd2,
        REG_BEATS_PER_BAR = 3'd3,
        REG_CROSS_LEVEL   = 3'd4,
        REG_FADE_SHAPE    = 3'd5,
        REG_FADE_LENGTH   = 3'd6,
        REG_DURATION      = 3'd7
    } t_reg_idx;

    localparam logic [1:0] MODE_SEQ    = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_THRESH = 2'd2;
    localparam logic [1:0] SHAPE_SMOOTH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BEATS,
        ST_POS_DIV,
        ST_FADE_DIV,
        ST_SMOOTH_SQ,
        ST_SMOOTH_MUL,
        ST_PROG_DIV,
        ST_OUT
    } t_seq_state;

    typedef struct packed {
        logic            start;
        logic [47:0]     dividend;
        logic [15:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [47:0]     quotient;
    } t_div_rsp;

endpackage

[rtl/core/bar_quantized_scene_sequencer_unit.sv]
`timescale 1ns / 1ps
// Timing: a tick runs through the beat carry loop and up to three divisions on the shared
// 48-bit divider before its result reaches the output register and o_out_valid.
// Throughput: one tick at a time; o_in_stall is high until the result is presented,
// and the next tick may be taken while that result waits in the output register.
// Reset: synchronous active-low; configuration and control registers load their defaults, datapath registers do not.
module bar_quantized_scene_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_tick_phase,
    input  logic        i_trigger_level,
    input  logic        i_reset_level,
    input  logic [15:0] i_signal_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_current_index,
    output logic [16:0] o_progress,
    output logic        o_transition_pulse,
    output logic [15:0] o_bars_elapsed,
    output logic [15:0] o_phase_echo,
    output logic [16:0] o_fade_amount,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import bqss_pkg::*;

    logic [3:0]  r_state_count;
    logic [1:0]  r_adv_mode, r_opts, r_shape;
    logic [5:0]  r_bpb;
    logic [15:0] r_cross;
    logic [13:0] r_flen;
    logic [63:0] r_dtab;

    logic [2:0]  r_act, n_act;
    logic [15:0] r_bars, n_bars;
    logic [4:0]  r_beats, n_beats;
    logic [15:0] r_lphase, n_lphase, r_lsig, n_lsig;
    logic        r_ltrig, n_ltrig, r_lrst, n_lrst;
    logic        r_pend, n_pend, r_done_f, n_done_f, r_fading, n_fading;
    logic [31:0] r_fstart, n_fstart;

    t_seq_state  r_st, n_st;
    logic [15:0] r_phase, n_phase;
    logic        r_fired, n_fired;
    logic [31:0] r_pos, n_pos;
    logic [16:0] r_t, n_t;
    logic [33:0] r_acc, n_acc;
    logic [16:0] r_prog, n_prog;
    logic        r_tedge, n_tedge, r_redge, n_redge;
    logic [15:0] r_sig, n_sig;
    logic [5:0]  r_bacc, n_bacc, r_bq, n_bq;

    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_o_idx;
    logic [16:0] r_o_prog, r_o_fade;
    logic        r_o_pulse;
    logic [15:0] r_o_bars, r_o_phase;

    t_div_req div_req;
    t_div_rsp div_rsp;

    bqss_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic        take;
    logic [5:0]  bpb_c;
    logic [3:0]  ns_c;
    logic        trig_edge, rst_edge, new_bar, adv;
    logic [15:0] bar_tmp;
    logic [16:0] bar_sum;
    logic [7:0]  dur;
    logic [3:0]  nxt;
    logic [32:0] diff;
    logic [16:0] t_c;
    logic [33:0] sq;
    logic [18:0] fac;
    logic [51:0] prod;

    assign bpb_c = (r_bpb == 6'd0) ? 6'd1 : (r_bpb > 6'd32) ? 6'd32 : r_bpb;
    assign ns_c  = (r_state_count == 4'd0) ? 4'd1 :
                   (r_state_count > 4'(MaxStates)) ? 4'(MaxStates) : r_state_count;
    assign o_cfg_ready = (r_st == ST_IDLE);
    assign o_in_stall  = (r_st != ST_IDLE);
    assign take = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= 4'd4;
            r_adv_mode    <= 2'd0;
            r_opts        <= 2'd3;
            r_bpb         <= 6'd4;
            r_cross       <= 16'd32768;
            r_shape       <= 2'd0;
            r_flen        <= '0;
            r_dtab        <= 64'd289360691352306692;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_STATE_COUNT:   r_state_count <= i_cfg_data[3:0];
                REG_ADVANCE_MODE:  r_adv_mode    <= i_cfg_data[1:0];
                REG_OPTION_FLAGS:  r_opts        <= i_cfg_data[1:0];
                REG_BEATS_PER_BAR: r_bpb         <= i_cfg_data[5:0];
                REG_CROSS_LEVEL:   r_cross       <= i_cfg_data[15:0];
                REG_FADE_SHAPE:    r_shape       <= i_cfg_data[1:0];
                REG_FADE_LENGTH:   r_flen        <= i_cfg_data[13:0];
                REG_DURATION:      r_dtab        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_act <= '0; r_bars <= '0; r_beats <= '0; r_lphase <= '0; r_lsig <= '0;
            r_ltrig <= 1'b0; r_lrst <= 1'b0; r_pend <= 1'b0; r_done_f <= 1'b0;
            r_fading <= 1'b0; r_fstart <= '0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_act <= n_act; r_bars <= n_bars; r_beats <= n_beats;
            r_lphase <= n_lphase; r_lsig <= n_lsig; r_ltrig <= n_ltrig;
            r_lrst <= n_lrst; r_pend <= n_pend; r_done_f <= n_done_f;
            r_fading <= n_fading; r_fstart <= n_fstart; r_ovalid <= n_ovalid;
        end
        r_phase <= n_phase; r_fired <= n_fired; r_pos <= n_pos;
        r_t <= n_t; r_acc <= n_acc; r_prog <= n_prog;
        r_tedge <= n_tedge; r_redge <= n_redge; r_sig <= n_sig;
        r_bacc <= n_bacc; r_bq <= n_bq;
        if (r_st == ST_OUT && !(r_ovalid && i_out_stall)) begin
            r_o_idx   <= r_act;
            r_o_prog  <= r_prog;
            r_o_pulse <= r_fired;
            r_o_bars  <= r_bars;
            r_o_phase <= r_phase;
            r_o_fade  <= r_t;
        end
    end

    always_comb begin
        n_st = r_st; n_act = r_act; n_bars = r_bars; n_beats = r_beats;
        n_lphase = r_lphase; n_lsig = r_lsig; n_ltrig = r_ltrig; n_lrst = r_lrst;
        n_pend = r_pend; n_done_f = r_done_f; n_fading = r_fading; n_fstart = r_fstart;
        n_phase = r_phase; n_fired = r_fired; n_pos = r_pos; n_t = r_t;
        n_acc = r_acc; n_prog = r_prog;
        n_tedge = r_tedge; n_redge = r_redge; n_sig = r_sig;
        n_bacc = r_bacc; n_bq = r_bq;
        n_ovalid = r_ovalid && i_out_stall;
        div_req = '0;
        trig_edge = 1'b0; rst_edge = 1'b0; new_bar = 1'b0; adv = 1'b0;
        bar_tmp = r_bars; bar_sum = '0; nxt = '0;
        dur = r_dtab[{r_act, 3'b000} +: 8];
        diff = '0; t_c = '0; sq = '0; fac = '0; prod = '0;
        case (r_st)
            ST_IDLE: begin
                if (take) begin
                    trig_edge = i_trigger_level && !r_ltrig;
                    rst_edge  = i_reset_level && !r_lrst;
                    n_ltrig = i_trigger_level;
                    n_lrst  = i_reset_level;
                    n_phase = i_tick_phase;
                    n_fired = 1'b0;
                    n_t     = '0;
                    n_lphase = i_tick_phase;
                    n_tedge = trig_edge;
                    n_redge = rst_edge;
                    n_sig   = i_signal_sample;
                    n_bq    = '0;
                    if (rst_edge) begin
                        n_act = '0; n_bars = '0; n_beats = '0;
                        n_pend = 1'b0; n_done_f = 1'b0;
                        n_bacc = '0;
                    end else begin
                        n_bacc = {1'b0, r_beats} +
                            6'(({1'b0, i_tick_phase} + 17'd32768) < {1'b0, r_lphase});
                    end
                    n_st = ST_BEATS;
                end
            end
            ST_BEATS: begin
                // carry whole bars out of the beat count, one per cycle
                if (r_bacc >= bpb_c) begin
                    n_bacc = r_bacc - bpb_c;
                    n_bq   = r_bq + 6'd1;
                end else begin
                    n_beats = r_bacc[4:0];
                    if (r_bq != 6'd0) begin
                        new_bar = 1'b1;
                        bar_sum = {1'b0, r_bars} + 17'(r_bq);
                        bar_tmp = bar_sum[16] ? 16'hFFFF : bar_sum[15:0];
                    end
                    if (!r_done_f && !r_redge) begin
                        case (r_adv_mode)
                            MODE_SEQ: adv = (dur != 8'd0) && (bar_tmp >= {8'd0, dur});
                            MODE_MANUAL: adv = r_tedge;
                            MODE_THRESH: begin
                                adv = ((r_lsig < r_cross) != (r_sig < r_cross));
                                n_lsig = r_sig;
                            end
                            default: adv = 1'b0;
                        endcase
                        if (dur == 8'd0 && r_tedge) adv = 1'b1;
                        if (adv && r_opts[0] && !new_bar) begin
                            n_pend = 1'b1;
                            adv = 1'b0;
                        end
                        if (n_pend && new_bar) begin
                            n_pend = 1'b0;
                            adv = 1'b1;
                        end
                    end
                    n_bars = bar_tmp;
                    if (adv) begin
                        nxt = {1'b0, r_act} + 4'd1;
                        if (nxt >= ns_c) begin
                            if (r_opts[1]) nxt = '0;
                            else begin
                                n_done_f = 1'b1;
                                nxt = {1'b0, r_act};
                            end
                        end
                        if (nxt[2:0] != r_act) begin
                            n_act = nxt[2:0]; n_bars = '0; n_beats = '0;
                            n_fired = 1'b1;
                        end
                    end
                    div_req.start    = 1'b1;
                    div_req.dividend = 48'({n_beats, 16'd0}) + 48'(r_phase);
                    div_req.divisor  = 16'(bpb_c);
                    n_st = ST_POS_DIV;
                end
            end
            ST_POS_DIV: begin
                if (div_rsp.done) begin
                    n_pos = {r_bars, 16'd0} + div_rsp.quotient[31:0];
                    if (r_fired && r_shape != 2'd0 && r_flen != 14'd0) begin
                        n_fading = 1'b1;
                        n_fstart = {r_bars, 16'd0} + div_rsp.quotient[31:0];
                    end
                    if (n_fading) begin
                        if (r_flen == 14'd0) begin
                            n_t = 17'h10000;
                            n_st = ST_SMOOTH_SQ;
                        end else if (n_pos <= n_fstart) begin
                            n_t = '0;
                            n_st = ST_SMOOTH_SQ;
                        end else begin
                            diff = {1'b0, n_pos} - {1'b0, n_fstart};
                            div_req.start    = 1'b1;
                            div_req.dividend = 48'({diff[31:0], 8'd0});
                            div_req.divisor  = {2'b00, r_flen};
                            n_st = ST_FADE_DIV;
                        end
                    end else begin
                        n_st = ST_PROG_DIV;
                        div_req.start    = 1'b1;
                        div_req.dividend = 48'(n_pos);
                        div_req.divisor  = {8'd0, dur};
                    end
                end
            end
            ST_FADE_DIV: begin
                if (div_rsp.done) begin
                    n_t = (div_rsp.quotient > 48'h10000) ? 17'h10000 : div_rsp.quotient[16:0];
                    n_st = ST_SMOOTH_SQ;
                end
            end
            ST_SMOOTH_SQ: begin
                sq = r_t * r_t;
                n_acc = sq >> FracBits;
                n_st = (r_shape == SHAPE_SMOOTH) ? ST_SMOOTH_MUL : ST_PROG_DIV;
                if (r_shape != SHAPE_SMOOTH) begin
                    if (r_t[16]) n_fading = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.dividend = 48'(r_pos);
                    div_req.divisor  = {8'd0, dur};
                end
            end
            ST_SMOOTH_MUL: begin
                fac  = 19'd196608 - {1'b0, r_t, 1'b0};
                prod = r_acc[17:0] * fac;
                t_c  = 17'(prod >> FracBits);
                n_t  = t_c;
                if (t_c[16]) n_fading = 1'b0;
                div_req.start    = 1'b1;
                div_req.dividend = 48'(r_pos);
                div_req.divisor  = {8'd0, dur};
                n_st = ST_PROG_DIV;
            end
            ST_PROG_DIV: begin
                if (dur == 8'd0) begin
                    n_prog = '0;
                    n_st = ST_OUT;
                end else if (div_rsp.done) begin
                    n_prog = (div_rsp.quotient > 48'h10000) ? 17'h10000 :
                             div_rsp.quotient[16:0];
                    n_st = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!(r_ovalid && i_out_stall)) begin
                    n_ovalid = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_out_valid        = r_ovalid;
    assign o_current_index    = r_o_idx;
    assign o_progress         = r_o_prog;
    assign o_transition_pulse = r_o_pulse;
    assign o_bars_elapsed     = r_o_bars;
    assign o_phase_echo       = r_o_phase;
    assign o_fade_amount      = r_o_fade;

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_in_stall) else $error("accepted while busy");
    a_prog_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_progress <= 17'h10000) else $error("progress overflow");
    a_fade_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fade_amount <= 17'h10000) else $error("fade overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid) else $error("result lost");
`endif
endmodule

[rtl/core/bqss_divider.sv]
`timescale 1ns / 1ps
module bqss_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bqss_pkg::t_div_req i_req,
    output bqss_pkg::t_div_rsp o_rsp
);
    import bqss_pkg::*;

    logic [47:0] r_quot, n_quot;
    logic [16:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [15:0] r_den, n_den;
    logic [16:0] sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_den  <= n_den;
    end

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_busy = r_busy;
        n_done = 1'b0;
        sh     = {r_rem[15:0], r_quot[47]};
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_den  = i_req.divisor;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[46:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                n_rem     = sh - {1'b0, r_den};
                n_quot[0] = 1'b1;
            end else begin
                n_rem = sh;
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("busy after done");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 6'd47) else $error("count overrun");
`endif
endmodule
